// ===== hw/rtl/run_segment_gap_detect_assert.svh =====
// Assertion macros for run_segment_gap_detect.sv. Each use names the clock clk
// and the active-low reset rst_n of the including module.
`ifndef RUN_SEGMENT_GAP_DETECT_ASSERT_SVH
`define RUN_SEGMENT_GAP_DETECT_ASSERT_SVH

// Same-cycle implication.
`define RSGD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define RSGD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rsgd_pkg.sv =====
`default_nettype none

package rsgd_pkg;

  typedef enum logic [1:0] {
    CLS_BLACK = 2'd0,
    CLS_RED   = 2'd1,
    CLS_WHITE = 2'd2
  } cls_t;

  localparam logic [7:0] BLACK_LEVEL_RST = 8'd0;
  localparam logic [7:0] RED_LEVEL_RST   = 8'd128;

  localparam logic CFG_IDX_BLACK = 1'b0;
  localparam logic CFG_IDX_RED   = 1'b1;

  typedef struct packed {
    logic red_seen;
    logic gap_seen;
    logic blocked_line;
    logic blocked_frame;
  } gap_t;

  typedef struct packed {
    logic [12:0] seg_key;
    cls_t        seg_class;
    logic [12:0] seg_length;
    logic [11:0] seg_mid;
    logic        line_done;
    logic        line_blocked;
    logic        frame_blocked;
  } res_t;

  // Update the obstruction tracker with one closing segment.
  function automatic gap_t track_gap(gap_t s, cls_t c);
    gap_t r;
    r = s;
    if (c == CLS_RED) begin
      if (s.red_seen && s.gap_seen) begin
        r.blocked_line  = 1'b1;
        r.blocked_frame = 1'b1;
      end
      r.red_seen = 1'b1;
      r.gap_seen = 1'b0;
    end else if (s.red_seen) begin
      r.gap_seen = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rsgd_in_if.sv =====
`default_nettype none

interface rsgd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       last_in_line;
  logic       frame_start;

  modport source (output valid, output pixel_value, output last_in_line,
                  output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input last_in_line,
                  input frame_start, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rsgd_out_if.sv =====
`default_nettype none

interface rsgd_out_if;
  import rsgd_pkg::*;

  logic        valid;
  logic        ready;
  logic [12:0] seg_key;
  cls_t        seg_class;
  logic [12:0] seg_length;
  logic [11:0] seg_mid;
  logic        line_done;
  logic        line_blocked;
  logic        frame_blocked;

  modport source (output valid, output seg_key, output seg_class, output seg_length,
                  output seg_mid, output line_done, output line_blocked,
                  output frame_blocked, input ready);
  modport sink   (input valid, input seg_key, input seg_class, input seg_length,
                  input seg_mid, input line_done, input line_blocked,
                  input frame_blocked, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/run_segment_gap_detect.sv =====
// Channel  | Dir | Handshake       | Payload
// ---------+-----+-----------------+-------------------------------------------------
// in_ch    | in  | valid / ready   | pixel_value, last_in_line, frame_start
// out_ch   | out | valid / ready   | seg_key, seg_class, seg_length, seg_mid,
//          |     |                 | line_done, line_blocked, frame_blocked
// cfg_*    | in  | cfg_we only     | cfg_idx, cfg_wdata
//
// One pixel item per cycle while the queue has room: an item sits in the input
// register, then its segment results (zero, one or two) land in a four-entry
// result queue. The input register advances whenever the queue holds two items
// or fewer, so the rate is one pixel per cycle while the sink keeps up; a pixel
// that closes two segments puts two results in the queue.
// Reset (rst_n, synchronous, active low) clears line and frame state, loads the
// level registers with black 0 and red 128, and empties the queue.
// A stalled sink fills the queue and then drops in_ch.ready.
`default_nettype none

`include "run_segment_gap_detect_assert.svh"

module run_segment_gap_detect #(
  parameter int MAX_LINE_PIXELS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rsgd_in_if.sink          in_ch,
  rsgd_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [7:0]  cfg_wdata
);
  import rsgd_pkg::*;

  // Position width follows the line length; arithmetic width covers both the
  // position sum and the 13-bit output fields.
  localparam int PW = (MAX_LINE_PIXELS > 2) ? $clog2(MAX_LINE_PIXELS) : 1;
  localparam int CW = (PW + 1 > 13) ? PW + 1 : 13;
  localparam logic [PW-1:0] POS_LAST = PW'(MAX_LINE_PIXELS - 1);
  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam logic [QAW:0] QROOM = 3'd2;

  // ---------------- configuration ----------------
  logic [7:0] black_level_r;
  logic [7:0] red_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_level_r <= BLACK_LEVEL_RST;
      red_level_r   <= RED_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IDX_BLACK: black_level_r <= cfg_wdata;
        CFG_IDX_RED:   red_level_r   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic       pv_r;
  logic [7:0] px_r;
  logic       last_r;
  logic       fs_r;
  logic [QAW:0] cnt_r;
  logic       advance;
  logic       in_acc;

  // Advance the held pixel only when the queue can take two results.
  assign advance     = pv_r && (cnt_r <= QROOM);
  assign in_ch.ready = !pv_r || advance;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (in_acc) begin
      pv_r <= 1'b1;
    end else if (advance) begin
      pv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r   <= in_ch.pixel_value;
      last_r <= in_ch.last_in_line;
      fs_r   <= in_ch.frame_start;
    end
  end

  // ---------------- line state ----------------
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] start_r, start_nxt;
  cls_t          prev_r, prev_nxt;
  logic [12:0]   seg_r, seg_nxt;
  gap_t          gap_r, gap_nxt;

  cls_t          cls;
  gap_t          tr0, tr_a, tr_b;
  logic          emit_a, end_line;
  logic [PW-1:0] start1;
  logic [12:0]   cnt_a, cnt_b;
  logic [CW-1:0] pos_x, start_x, start1_x;
  logic [CW-1:0] len_a, len_b, sum_a, sum_b;
  res_t          res_a, res_b;

  always_comb begin
    // Classify: black wins when both levels match.
    if (px_r == black_level_r) begin
      cls = CLS_BLACK;
    end else if (px_r == red_level_r) begin
      cls = CLS_RED;
    end else begin
      cls = CLS_WHITE;
    end

    // Frame start clears the frame verdict before anything else.
    tr0 = gap_r;
    if (fs_r) begin
      tr0.blocked_frame = 1'b0;
    end

    // Class change closes the open run (not on the first pixel of a line).
    emit_a = (pos_r != '0) && (cls != prev_r);
    tr_a   = emit_a ? track_gap(tr0, prev_r) : tr0;
    cnt_a  = seg_r + {12'd0, emit_a};

    if (pos_r == '0) begin
      start1 = '0;
    end else if (emit_a) begin
      start1 = pos_r;
    end else begin
      start1 = start_r;
    end

    // Last pixel, or an overlong line, closes the final run.
    end_line = last_r || (pos_r == POS_LAST);
    tr_b     = end_line ? track_gap(tr_a, cls) : tr_a;
    cnt_b    = cnt_a + 13'd1;

    pos_x    = CW'(pos_r);
    start_x  = CW'(start_r);
    start1_x = CW'(start1);

    // Closed run spans start_r .. pos_r-1.
    len_a = pos_x - start_x;
    sum_a = start_x + pos_x - CW'(1);
    // Final run spans start1 .. pos_r.
    len_b = pos_x - start1_x + CW'(1);
    sum_b = start1_x + pos_x;

    res_a.seg_key       = cnt_a;
    res_a.seg_class     = prev_r;
    res_a.seg_length    = len_a[12:0];
    res_a.seg_mid       = sum_a[12:1];
    res_a.line_done     = 1'b0;
    res_a.line_blocked  = tr_a.blocked_line;
    res_a.frame_blocked = tr_a.blocked_frame;

    res_b.seg_key       = cnt_b;
    res_b.seg_class     = cls;
    res_b.seg_length    = len_b[12:0];
    res_b.seg_mid       = sum_b[12:1];
    res_b.line_done     = 1'b1;
    res_b.line_blocked  = tr_b.blocked_line;
    res_b.frame_blocked = tr_b.blocked_frame;

    // Hold state unless the pixel advances.
    pos_nxt   = pos_r;
    start_nxt = start_r;
    prev_nxt  = prev_r;
    seg_nxt   = seg_r;
    gap_nxt   = gap_r;
    if (advance) begin
      if (end_line) begin
        // Drop all per-line state; keep the frame verdict.
        pos_nxt   = '0;
        start_nxt = '0;
        prev_nxt  = CLS_BLACK;
        seg_nxt   = '0;
        gap_nxt   = '0;
        gap_nxt.blocked_frame = tr_b.blocked_frame;
      end else begin
        pos_nxt   = pos_r + PW'(1);
        start_nxt = start1;
        prev_nxt  = cls;
        seg_nxt   = cnt_a;
        gap_nxt   = tr_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      prev_r  <= CLS_BLACK;
      seg_r   <= '0;
      gap_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      prev_r  <= prev_nxt;
      seg_r   <= seg_nxt;
      gap_r   <= gap_nxt;
    end
  end

  // ---------------- result queue ----------------
  res_t           q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW-1:0] wp1;
  logic           we0, we1, pop;
  res_t           wd0;
  logic [QAW:0]   n_wr;

  assign we0  = advance && (emit_a || end_line);
  assign we1  = advance && emit_a && end_line;
  assign wd0  = emit_a ? res_a : res_b;
  assign wp1  = wp_r + QAW'(1);
  assign n_wr = {{QAW{1'b0}}, we0} + {{QAW{1'b0}}, we1};
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (we0 && (wp_r == QAW'(i))) begin
        q_r[i] <= wd0;
      end
      if (we1 && (wp1 == QAW'(i))) begin
        q_r[i] <= res_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + n_wr[QAW-1:0];
      rp_r  <= rp_r + QAW'(pop);
      cnt_r <= cnt_r + n_wr - {{QAW{1'b0}}, pop};
    end
  end

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.seg_key       = q_r[rp_r].seg_key;
  assign out_ch.seg_class     = q_r[rp_r].seg_class;
  assign out_ch.seg_length    = q_r[rp_r].seg_length;
  assign out_ch.seg_mid       = q_r[rp_r].seg_mid;
  assign out_ch.line_done     = q_r[rp_r].line_done;
  assign out_ch.line_blocked  = q_r[rp_r].line_blocked;
  assign out_ch.frame_blocked = q_r[rp_r].frame_blocked;

  // ---------------- checks ----------------
  `RSGD_ASSERT_NOW(a_queue_bound, 1'b1, cnt_r <= 3'd4)
  `RSGD_ASSERT_NOW(a_pos_bound, 1'b1, pos_r <= POS_LAST)
  `RSGD_ASSERT_NOW(a_block_needs_red, gap_r.blocked_line, gap_r.red_seen)
  `RSGD_ASSERT_NEXT(a_line_end_clears, advance && end_line, pos_r == '0 && seg_r == '0)

endmodule

`default_nettype wire

// ===== test/tb_run_segment_gap_detect.sv =====
module tb_run_segment_gap_detect;
  import rsgd_pkg::*;

  // Longest line the block accepts before it forces a line end.
  localparam int LINE_MAX = 4096;
  // Cycles the result sink holds off during the pressure stretch.
  localparam int HOLD_CYCLES = 300;
  // Cycles to let pass after the last expected segment, for pixels still in flight.
  localparam int SETTLE_CYCLES = 8;

  // Tracks the segmenter state for every accepted pixel item and keeps the
  // segments it should report, oldest first.
  class seg_scoreboard;
    logic [7:0]  black_lvl;
    logic [7:0]  red_lvl;
    logic [11:0] pos;
    logic [11:0] run_first;
    cls_t        open_cls;
    logic [12:0] seg_cnt;
    bit          red_seen;
    bit          gap_open;
    bit          blk_line;
    bit          blk_frame;
    res_t        expected_segs[$];
    int          errors;

    function new();
      black_lvl = BLACK_LEVEL_RST;
      red_lvl   = RED_LEVEL_RST;
      clear_line();
      blk_frame = 1'b0;
      errors    = 0;
    endfunction

    function void clear_line();
      pos       = '0;
      run_first = '0;
      open_cls  = CLS_BLACK;
      seg_cnt   = '0;
      red_seen  = 1'b0;
      gap_open  = 1'b0;
      blk_line  = 1'b0;
    endfunction

    function void set_level(logic idx, logic [7:0] v);
      if (idx == CFG_IDX_BLACK) begin
        black_lvl = v;
      end else begin
        red_lvl = v;
      end
    endfunction

    function int pending();
      return expected_segs.size();
    endfunction

    // Close one run: update the obstruction tracker, then queue the segment.
    function void close_segment(cls_t c, logic [11:0] first, logic [11:0] last, bit done);
      res_t        s;
      logic [12:0] sum;
      if (c == CLS_RED) begin
        // a second red run with something else in between blocks the lane
        if (red_seen && gap_open) begin
          blk_line  = 1'b1;
          blk_frame = 1'b1;
        end
        red_seen = 1'b1;
        gap_open = 1'b0;
      end else if (red_seen) begin
        gap_open = 1'b1;
      end
      seg_cnt         = seg_cnt + 13'd1;
      sum             = {1'b0, first} + {1'b0, last};
      s.seg_key       = seg_cnt;
      s.seg_class     = c;
      s.seg_length    = {1'b0, last} - {1'b0, first} + 13'd1;
      s.seg_mid       = sum[12:1];
      s.line_done     = done;
      s.line_blocked  = blk_line;
      s.frame_blocked = blk_frame;
      expected_segs.push_back(s);
    endfunction

    function void note_pixel(logic [7:0] px, bit last, bit fs);
      cls_t c;
      if (fs) blk_frame = 1'b0;
      // black wins when both levels match
      if (px == black_lvl) c = CLS_BLACK;
      else if (px == red_lvl) c = CLS_RED;
      else c = CLS_WHITE;
      if (pos == 12'd0) begin
        run_first = '0;
      end else if (c != open_cls) begin
        close_segment(open_cls, run_first, pos - 12'd1, 1'b0);
        run_first = pos;
      end
      open_cls = c;
      if (last || pos == 12'(LINE_MAX - 1)) begin
        close_segment(c, run_first, pos, 1'b1);
        clear_line();
      end else begin
        pos = pos + 12'd1;
      end
    endfunction

    function void compare_field(string name, logic [12:0] want, logic [12:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_segment(res_t got);
      res_t want;
      if (expected_segs.size() == 0) begin
        $error("segment key %0d arrived with no segment expected", got.seg_key);
        errors++;
        return;
      end
      want = expected_segs.pop_front();
      compare_field("seg_key",       want.seg_key,       got.seg_key);
      compare_field("seg_class",     want.seg_class,     got.seg_class);
      compare_field("seg_length",    want.seg_length,    got.seg_length);
      compare_field("seg_mid",       want.seg_mid,       got.seg_mid);
      compare_field("line_done",     want.line_done,     got.line_done);
      compare_field("line_blocked",  want.line_blocked,  got.line_blocked);
      compare_field("frame_blocked", want.frame_blocked, got.frame_blocked);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_wdata;

  rsgd_in_if  in_ch();
  rsgd_out_if out_ch();

  seg_scoreboard sb = new();

  // Flags shared between the stimulus and the result sink, and the sent-item count.
  bit hold_req = 1'b0;   // ask the sink for one long hold-off
  bit no_idle  = 1'b0;   // suppress random gaps on both sides
  int items_sent = 0;

  run_segment_gap_detect dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one pixel item, hold it until accepted, then tell the scoreboard.
  // Each call starts and ends in the time step of a rising edge.
  task automatic send_pixel(input logic [7:0] px, input bit last, input bit fs);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < 8) gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pixel_value  <= px;
    in_ch.last_in_line <= last;
    in_ch.frame_start  <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_pixel(px, last, fs);
    items_sent++;
  endtask

  // Mostly the two levels, sometimes any grey value.
  function automatic logic [7:0] pick_pixel();
    int r;
    r = $urandom_range(9);
    if (r < 4) return sb.black_lvl;
    if (r < 7) return sb.red_lvl;
    return 8'($urandom_range(255));
  endfunction

  // Send one scan line built from runs of equal pixels; a noisy line is
  // random pixels with random line ends and frame starts.
  task automatic send_line(input bit noisy);
    int         len;
    int         run_len;
    int         i;
    logic [7:0] px;
    bit         fs_line;
    len     = ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(24, 1);
    fs_line = ($urandom_range(7) == 0);
    i = 0;
    while (i < len) begin
      run_len = $urandom_range(6, 1);
      px      = pick_pixel();
      repeat (run_len) begin
        if (i < len) begin
          if (noisy) begin
            send_pixel(8'($urandom_range(255)), $urandom_range(7) == 0,
                       $urandom_range(15) == 0);
          end else begin
            send_pixel(px, i == len - 1, (i == 0 && fs_line) || $urandom_range(39) == 0);
          end
          i++;
        end
      end
    end
  endtask

  // Drop valid, wait for every expected segment, then let in-flight pixels settle.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    sb.set_level(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] blk, input logic [7:0] red, input int count);
    int target;
    wait_drain();
    write_reg(CFG_IDX_BLACK, blk);
    write_reg(CFG_IDX_RED, red);
    target = items_sent + count;
    while (items_sent < target) send_line($urandom_range(6) == 0);
  endtask

  // Result sink: check every accepted segment, stall at random, and hold off
  // for a long stretch on request.
  initial begin : result_sink
    res_t got;
    int   hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.seg_key       = out_ch.seg_key;
        got.seg_class     = out_ch.seg_class;
        got.seg_length    = out_ch.seg_length;
        got.seg_mid       = out_ch.seg_mid;
        got.line_done     = out_ch.line_done;
        got.line_blocked  = out_ch.line_blocked;
        got.frame_blocked = out_ch.frame_blocked;
        sb.check_segment(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 8);
      end
    end
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("run_segment_gap_detect test failed");
    $finish;
  end

  initial begin : stimulus
    int target;
    bit hold_done;
    bit drain_done;
    // Hold every input at a known value from the start.
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_IDX_BLACK;
    cfg_wdata          <= 8'd0;
    in_ch.valid        <= 1'b0;
    in_ch.pixel_value  <= 8'd0;
    in_ch.last_in_line <= 1'b0;
    in_ch.frame_start  <= 1'b0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines at the reset levels (black 0, red 128).
    // Red, black, red blocks the lane; the white run after it still reports.
    send_pixel(8'd0,   1'b0, 1'b1);
    send_pixel(8'd128, 1'b0, 1'b0);
    send_pixel(8'd128, 1'b0, 1'b0);
    send_pixel(8'd0,   1'b0, 1'b0);
    send_pixel(8'd128, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);
    // Single-pixel line.
    send_pixel(8'd255, 1'b1, 1'b0);
    // Class change on the last pixel: two segments from one item.
    send_pixel(8'd0,   1'b0, 1'b0);
    send_pixel(8'd128, 1'b1, 1'b0);
    // Frame start in mid-line clears only the frame verdict; the line blocks again.
    send_pixel(8'd128, 1'b0, 1'b0);
    send_pixel(8'd7,   1'b0, 1'b0);
    send_pixel(8'd128, 1'b0, 1'b1);
    send_pixel(8'd128, 1'b1, 1'b0);
    // Fresh frame: verdicts start clear.
    send_pixel(8'd5,   1'b0, 1'b1);
    send_pixel(8'd5,   1'b1, 1'b0);
    // Neighbors of the levels are white.
    send_pixel(8'd127, 1'b0, 1'b0);
    send_pixel(8'd129, 1'b0, 1'b0);
    send_pixel(8'd1,   1'b1, 1'b0);

    // Random lines at the reset levels, with one long sink hold-off while
    // pixels keep coming, then a full pause until everything has drained.
    target = items_sent + 200;
    while (items_sent < target) begin
      if (!hold_done && items_sent >= target - 160) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= target - 60) begin
        wait_drain();
        drain_done = 1'b1;
      end
      send_line($urandom_range(6) == 0);
    end

    // Equal levels: matching pixels are black.
    run_phase(8'd0, 8'd0, 200);
    // A stretch with no gaps on either side.
    no_idle = 1'b1;
    run_phase(8'd255, 8'd255, 200);
    no_idle = 1'b0;
    run_phase(8'd255, 8'd0, 200);
    run_phase(8'd0, 8'd255, 200);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 200);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 200);
    run_phase(BLACK_LEVEL_RST, RED_LEVEL_RST, 150);

    wait_drain();
    if (sb.errors == 0) begin
      $display("run_segment_gap_detect test passed");
    end else begin
      $display("run_segment_gap_detect test failed");
    end
    $finish;
  end

endmodule

// ===== run_segment_gap_detect.f =====
+incdir+hw/rtl
hw/rtl/rsgd_pkg.sv
hw/rtl/rsgd_in_if.sv
hw/rtl/rsgd_out_if.sv
hw/rtl/run_segment_gap_detect.sv
test/tb_run_segment_gap_detect.sv
